### sv/splitter_bucket_classifier_top_macros.svh
// ---------------------------------------------------------------------------
// splitter bucket classifier assertion macros
// concurrent checks in the house form, one use per line
// ---------------------------------------------------------------------------
`ifndef SPLITTER_BUCKET_CLASSIFIER_TOP_MACROS_SVH
`define SPLITTER_BUCKET_CLASSIFIER_TOP_MACROS_SVH

// same-cycle implication
`define SBC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("splitter bucket classifier check failed");

// next-cycle implication
`define SBC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("splitter bucket classifier check failed");

`endif

### sv/sbc_pkg.sv
// ---------------------------------------------------------------------------
// sbc_pkg
// shared types and codes of the splitter bucket classifier
// ---------------------------------------------------------------------------
package sbc_pkg;

   localparam int DEF_MAX_CLASSES = 64;
   localparam int DEF_KEY_BITS    = 32;
   localparam int DEF_QUOTA_BITS  = 16;

   // item kinds carried on tuser
   localparam logic KIND_LOAD     = 1'b0;
   localparam logic KIND_CLASSIFY = 1'b1;

   // configuration register indexes
   localparam logic REG_CLASS_COUNT = 1'b0;
   localparam logic REG_USE_COUNTS  = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } sbc_state_type;

endpackage

### sv/splitter_bucket_classifier_top.sv
// ---------------------------------------------------------------------------
// splitter_bucket_classifier_top
// splitter table with quota read-modify-write and in-order bucket scan
// ---------------------------------------------------------------------------
// Usage:
//   req_* is the input stream. tuser carries the kind: a load transfer writes
//   one splitter key and its equal-key quota into slot entry_index (slots past
//   the table end are dropped); a classify transfer scans the splitters and
//   yields one rsp_* transfer with the bucket index. Loads give no response.
//   csr_* writes class_count (index 0) and use_counts (index 1); the user
//   must write them only while idle, as the block does not enforce it. A
//   classify reads one splitter a cycle, unless the output stalls, from the
//   table memory's single read port; the read data is registered, so reads
//   run one slot ahead of the compare. The response is registered with the
//   bucket index, and the next request is taken only once the scan is over.
//   On a stop at an equal splitter with quota left, the quota is decremented
//   in the same cycle through the write port.
//   Reset sets class_count to 1 and use_counts to 1 and holds req_tready low;
//   the table is not cleared, so every scanned slot must be loaded first.
//   The response sits in an output register; a new request is still taken
//   while it waits. While the register is full and rsp_tready is low, the
//   scan holds where it is and none of its memory accesses moves.
// ---------------------------------------------------------------------------
`include "splitter_bucket_classifier_top_macros.svh"

module splitter_bucket_classifier_top #(
   parameter int  MAX_CLASSES = sbc_pkg::DEF_MAX_CLASSES,
   parameter int  KEY_BITS    = sbc_pkg::DEF_KEY_BITS,
   parameter int  QUOTA_BITS  = sbc_pkg::DEF_QUOTA_BITS,
   localparam int IDX_W       = $clog2(MAX_CLASSES),
   localparam int CNT_W       = $clog2(MAX_CLASSES + 1),
   localparam int IN_W        = IDX_W + KEY_BITS + QUOTA_BITS,
   localparam int IN_TW       = ((IN_W + 7) / 8) * 8,
   localparam int OUT_TW      = ((IDX_W + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   // request stream
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [IN_TW-1:0]  req_tdata,   // entry_index, key_value, equal_quota, zero pad
   input  logic              req_tuser,   // kind
   // response stream
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [OUT_TW-1:0] rsp_tdata,   // bucket_index, zero pad
   // configuration writes
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [CNT_W-1:0]  csr_data
);
   import sbc_pkg::*;

   localparam int DEPTH = MAX_CLASSES - 1;
   localparam int MEM_W = KEY_BITS + QUOTA_BITS;

   // request fields
   logic [IDX_W-1:0]      req_entry;
   logic [KEY_BITS-1:0]   req_key;
   logic [QUOTA_BITS-1:0] req_quota;
   logic                  req_accept;

   assign req_entry  = req_tdata[IDX_W-1:0];
   assign req_key    = req_tdata[IDX_W +: KEY_BITS];
   assign req_quota  = req_tdata[IDX_W + KEY_BITS +: QUOTA_BITS];
   assign req_accept = req_tvalid && req_tready;

   // configuration
   logic [CNT_W-1:0] class_count_ff;
   logic             use_counts_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         class_count_ff <= CNT_W'(1);
         use_counts_ff  <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_CLASS_COUNT: class_count_ff <= csr_data;
            REG_USE_COUNTS:  use_counts_ff  <= csr_data[0];
            default:         ;
         endcase
      end
   end

   // scan control
   sbc_state_type         state_ff, state_in;
   logic [KEY_BITS-1:0]   key_ff;
   logic [CNT_W-1:0]      limit_ff, limit_in;
   logic [IDX_W-1:0]      pos_ff;
   logic [CNT_W-1:0]      rd_addr_ff;
   logic                  data_valid_ff;
   logic [MEM_W-1:0]      rd_data_ff;

   logic [KEY_BITS-1:0]   rd_key;
   logic [QUOTA_BITS-1:0] rd_quota;
   logic                  stall;
   logic                  limit_hit, key_lt, quota_hit, scan_stop, done;
   logic                  rd_en, quota_we, load_we;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_wr_addr;
   logic [MEM_W-1:0]      mem_wr_data;
   logic                  scanning, classify_accept;
   logic [CNT_W-1:0]      pos_ext;

   logic                  rsp_tvalid_ff;
   logic [IDX_W-1:0]      bucket_ff;

   assign rd_key          = rd_data_ff[KEY_BITS-1:0];
   assign rd_quota        = rd_data_ff[KEY_BITS +: QUOTA_BITS];
   assign stall           = rsp_tvalid_ff && !rsp_tready;
   assign scanning        = (state_ff == ST_SCAN);
   assign classify_accept = req_accept && (req_tuser == KIND_CLASSIFY);
   assign pos_ext         = CNT_W'(pos_ff);

   // class counts above the table size saturate
   assign limit_in = (class_count_ff > CNT_W'(MAX_CLASSES)) ? CNT_W'(MAX_CLASSES)
                                                            : class_count_ff;

   always_comb begin
      limit_hit = (pos_ext + 1'b1) >= limit_ff;
      key_lt    = key_ff < rd_key;
      quota_hit = (state_ff == ST_SCAN) && !limit_hit && data_valid_ff && !key_lt
                  && use_counts_ff && (key_ff == rd_key) && (rd_quota != '0);
      scan_stop = (state_ff == ST_SCAN)
                  && (limit_hit || (data_valid_ff && key_lt) || quota_hit);
      done      = scan_stop && !stall;
      quota_we  = quota_hit && !stall;
      rd_en     = (state_ff == ST_SCAN) && !stall && !scan_stop
                  && (rd_addr_ff < CNT_W'(DEPTH));
      load_we   = req_accept && (req_tuser == KIND_LOAD) && (CNT_W'(req_entry) < CNT_W'(DEPTH));
   end

   // single write port: loads while idle, quota updates while scanning
   always_comb begin
      mem_we      = load_we || quota_we;
      mem_wr_addr = pos_ff;
      mem_wr_data = {rd_quota - 1'b1, rd_key};
      if (load_we) begin
         mem_wr_addr = req_entry;
         mem_wr_data = {req_quota, req_key};
      end
   end

   // splitter table, each entry {quota, key}
   logic [MEM_W-1:0] table_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr_ff[IDX_W-1:0]];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_tuser == KIND_CLASSIFY)) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      case (state_ff)
         ST_IDLE: req_tready = !reset;
         ST_SCAN: req_tready = 1'b0;
         default: req_tready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         data_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_accept) begin
            data_valid_ff <= 1'b0;
         end else if ((state_ff == ST_SCAN) && !stall) begin
            data_valid_ff <= rd_en;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         key_ff     <= req_key;
         limit_ff   <= limit_in;
         pos_ff     <= '0;
         rd_addr_ff <= '0;
      end else if ((state_ff == ST_SCAN) && !stall && !scan_stop) begin
         // read runs one slot ahead of the compare
         if (data_valid_ff) pos_ff <= pos_ff + 1'b1;
         if (rd_en) rd_addr_ff <= rd_addr_ff + 1'b1;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (done) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) bucket_ff <= pos_ff;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = OUT_TW'(bucket_ff);

   `SBC_ASSERT_IMP(a_rsp_after_scan, clock, reset, $rose(rsp_tvalid_ff), $past(scanning))
   `SBC_ASSERT_IMP(a_pos_in_limit, clock, reset, scanning && (limit_ff != '0), pos_ext < limit_ff)
   `SBC_ASSERT_IMP(a_read_ahead, clock, reset, scanning && data_valid_ff, rd_addr_ff == pos_ext + 1'b1)
   `SBC_ASSERT_IMP(a_quota_write_ok, clock, reset, quota_we, use_counts_ff && data_valid_ff && !load_we)
   `SBC_ASSERT_NXT(a_classify_scans, clock, reset, classify_accept, state_ff == ST_SCAN)

endmodule

### test/splitter_bucket_classifier_top_tb.sv
// ---------------------------------------------------------------------------
// splitter_bucket_classifier_top_tb
// self-checking bench: splitter loads and key classification over a stream.
// A queue of requests feeds a clocked driver. Each accepted transfer updates
// a local copy of the splitter table and quotas, and each classify transfer
// queues its predicted bucket. A clocked monitor pops and compares every
// response. Both sides idle at random, and the receiver holds off once for a
// long stretch so that the block backs up.
// ---------------------------------------------------------------------------
module splitter_bucket_classifier_top_tb;

   import sbc_pkg::*;

   localparam int SPLIT_DEPTH = DEF_MAX_CLASSES - 1;
   localparam int IDX_W       = $clog2(DEF_MAX_CLASSES);
   localparam int CNT_W       = $clog2(DEF_MAX_CLASSES + 1);
   localparam int IN_W        = IDX_W + DEF_KEY_BITS + DEF_QUOTA_BITS;
   localparam int IN_TW       = ((IN_W + 7) / 8) * 8;
   localparam int OUT_TW      = ((IDX_W + 7) / 8) * 8;
   localparam int ITEM_TARGET = 1850;
   localparam int SETTLE_CYC  = 80;
   localparam int HOLD_CYC    = 500;

   typedef struct {
      bit                      kind;
      bit [IDX_W-1:0]          slot;
      bit [DEF_KEY_BITS-1:0]   key;
      bit [DEF_QUOTA_BITS-1:0] quota;
   } sbc_req_type;

   typedef struct {
      bit [DEF_KEY_BITS-1:0] key;
      bit [IDX_W-1:0]        bucket;
   } bucket_due_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [IN_TW-1:0]  req_tdata = '0;
   logic              req_tuser = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [OUT_TW-1:0] rsp_tdata;
   logic              csr_wr_en = 1'b0;
   logic              csr_index = 1'b0;
   logic [CNT_W-1:0]  csr_data = '0;

   splitter_bucket_classifier_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // local copy of the block state
   bit [DEF_KEY_BITS-1:0]   split_key   [SPLIT_DEPTH];
   bit [DEF_QUOTA_BITS-1:0] split_quota [SPLIT_DEPTH];
   bit [CNT_W-1:0]          cfg_class_count = CNT_W'(1);
   bit                      cfg_use_counts  = 1'b1;

   sbc_req_type    pending_req [$];
   bucket_due_type bucket_due  [$];
   sbc_req_type    cur_req;

   // stimulus side view of the table, used only to pick interesting keys
   bit [DEF_KEY_BITS-1:0] plan_key    [SPLIT_DEPTH];
   bit                    plan_loaded [SPLIT_DEPTH];

   int fault_count   = 0;
   int items_planned = 0;
   int n_loaded      = 0;
   int n_classified  = 0;
   int n_settings    = 0;
   int send_gap      = 0;
   int send_calm     = 0;
   int recv_gap      = 0;
   int recv_calm     = 0;
   int hold_left     = 0;
   int hold_seen     = 0;
   bit hold_done     = 1'b0;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #(8 * 1500000);
      $display("DONE: errors detected");
      $finish;
   end

   // idle cycles before the next transfer, with runs of back-to-back items
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 9);
   endfunction

   // update the table or compute the bucket for one accepted transfer
   function automatic void apply_request(input sbc_req_type r);
      int             lim;
      int             pos;
      bit             stop;
      bucket_due_type due;
      if (r.kind == KIND_LOAD) begin
         if (r.slot < SPLIT_DEPTH) begin
            split_key[r.slot]   = r.key;
            split_quota[r.slot] = r.quota;
         end
         n_loaded++;
      end else begin
         lim  = (cfg_class_count > DEF_MAX_CLASSES) ? DEF_MAX_CLASSES : int'(cfg_class_count);
         pos  = 0;
         stop = 1'b0;
         while (!stop && pos + 1 < lim && pos < SPLIT_DEPTH) begin
            if (r.key < split_key[pos]) begin
               stop = 1'b1;
            end else if (cfg_use_counts && r.key == split_key[pos] && split_quota[pos] != 0) begin
               split_quota[pos] = split_quota[pos] - 1'b1;
               stop = 1'b1;
            end else begin
               pos++;
            end
         end
         due.key    = r.key;
         due.bucket = pos[IDX_W-1:0];
         bucket_due.push_back(due);
         n_classified++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            apply_request(cur_req);
            send_gap = draw_wait(send_calm);
         end
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_req.size() != 0) begin
            cur_req = pending_req.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= cur_req.kind;
            req_tdata  <= {{(IN_TW - IN_W){1'b0}}, cur_req.quota, cur_req.key, cur_req.slot};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      bucket_due_type due;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (bucket_due.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("unexpected response: bucket %0d", rsp_tdata[IDX_W-1:0]);
            end else begin
               due = bucket_due.pop_front();
               if (rsp_tdata[IDX_W-1:0] !== due.bucket) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display("bucket mismatch for key %h: expected %0d, got %0d",
                              due.key, due.bucket, rsp_tdata[IDX_W-1:0]);
               end
            end
            recv_gap = draw_wait(recv_calm);
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (hold_left == 0);
         end
      end
   end

   // one long receiver hold-off while the sender keeps offering
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            hold_seen <= hold_seen + 1;
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end else if (!hold_done && hold_seen >= 150 && req_tvalid) begin
            hold_left <= HOLD_CYC;
            hold_done <= 1'b1;
         end
      end
   end

   function automatic void add_load(input int slot, input bit [31:0] key, input bit [15:0] quota);
      sbc_req_type r;
      r.kind  = KIND_LOAD;
      r.slot  = slot[IDX_W-1:0];
      r.key   = key;
      r.quota = quota;
      pending_req.push_back(r);
      items_planned++;
      if (slot < SPLIT_DEPTH) begin
         plan_key[slot]    = key;
         plan_loaded[slot] = 1'b1;
      end
   endfunction

   function automatic void add_classify(input bit [31:0] key);
      sbc_req_type r;
      r.kind  = KIND_CLASSIFY;
      r.slot  = IDX_W'($urandom_range(0, SPLIT_DEPTH));
      r.key   = key;
      r.quota = DEF_QUOTA_BITS'($urandom);
      pending_req.push_back(r);
      items_planned++;
   endfunction

   // wait until the stream is empty and no bucket is outstanding
   task automatic settle();
      while (!(pending_req.size() == 0 && !req_tvalid && bucket_due.size() == 0))
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input bit [CNT_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      if (idx == REG_CLASS_COUNT)
         cfg_class_count = value;
      else
         cfg_use_counts = value[0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int         cc;
      int         lim;
      int         need;
      int         mode;
      int         n;
      int         sel;
      int         slot;
      bit         refresh;
      bit [15:0]  quota;
      bit [31:0]  key;
      longint     acc;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: one bucket, nothing scanned
      add_classify(32'hFFFF_FFFF);
      add_classify(32'h0000_0000);
      settle();

      // zero buckets
      write_reg(REG_CLASS_COUNT, CNT_W'(0));
      n_settings++;
      add_classify(32'hA5A5_5A5A);
      settle();

      // small table with equal splitters, quota exhaustion and an ignored slot
      write_reg(REG_CLASS_COUNT, CNT_W'(4));
      write_reg(REG_USE_COUNTS, CNT_W'(1));
      n_settings++;
      add_load(0, 32'd100, 16'd2);
      add_load(1, 32'd100, 16'd0);
      add_load(2, 32'hFFFF_FFFF, 16'hFFFF);
      add_load(SPLIT_DEPTH, 32'd0, 16'd1);
      add_classify(32'd0);
      add_classify(32'd100);
      add_classify(32'd100);
      add_classify(32'd100);
      add_classify(32'd99);
      add_classify(32'd101);
      add_classify(32'hFFFF_FFFF);
      add_classify(32'hFFFF_FFFF);
      settle();

      // quotas ignored
      write_reg(REG_USE_COUNTS, CNT_W'(0));
      n_settings++;
      add_classify(32'd100);
      add_classify(32'hFFFF_FFFF);
      settle();

      while (items_planned < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0: cc = 0;
            1: cc = 1;
            2: cc = 2;
            3: cc = 64;
            4: cc = $urandom_range(65, 127);
            5: cc = 127;
            6: cc = $urandom_range(1, 64);
            default: cc = $urandom_range(2, 12);
         endcase
         write_reg(REG_CLASS_COUNT, CNT_W'(cc));
         write_reg(REG_USE_COUNTS, CNT_W'($urandom_range(0, 3) != 0));
         n_settings++;
         lim  = (cc > DEF_MAX_CLASSES) ? DEF_MAX_CLASSES : cc;
         need = (lim == 0) ? 0 : lim - 1;

         // load the scanned slots, sorted dense, sorted wide, or unsorted
         refresh = $urandom_range(0, 2) != 0;
         mode    = $urandom_range(0, 2);
         acc     = (mode == 0) ? $urandom_range(0, 8) : $urandom_range(0, 32'h0FFF_FFFF);
         for (int i = 0; i < need; i++) begin
            if (mode == 0)
               acc += $urandom_range(0, 2);
            else
               acc += $urandom_range(0, 32'h03FF_FFFF);
            if (acc > 64'hFFFF_FFFF)
               acc = 64'hFFFF_FFFF;
            key   = (mode == 2) ? $urandom : acc[31:0];
            quota = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
            if (refresh || !plan_loaded[i])
               add_load(i, key, quota);
         end

         n = $urandom_range(20, 60);
         for (int j = 0; j < n; j++) begin
            sel = $urandom_range(0, 19);
            if (sel < 3) begin
               // stray load, the slot past the table end among them
               slot  = $urandom_range(0, SPLIT_DEPTH);
               key   = (need > 0 && sel < 2) ? plan_key[$urandom_range(0, need - 1)] : $urandom;
               quota = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
               add_load(slot, key, quota);
            end else if (need == 0 || sel >= 17) begin
               add_classify($urandom);
            end else if (sel < 12) begin
               add_classify(plan_key[$urandom_range(0, need - 1)] + $urandom_range(0, 2) - 1);
            end else begin
               add_classify(plan_key[$urandom_range(0, need - 1)] + $urandom_range(0, 510) - 255);
            end
         end
         settle();
      end

      settle();
      if (bucket_due.size() != 0) begin
         $display("%0d buckets never arrived", bucket_due.size());
         fault_count += bucket_due.size();
      end
      $display("run covered %0d loads and %0d classifications over %0d register settings",
               n_loaded, n_classified, n_settings);
      if (fault_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/sbc_pkg.sv
sv/splitter_bucket_classifier_top.sv
test/splitter_bucket_classifier_top_tb.sv
